// ===== hw/rtl/srct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srct_pkg
// Shared types, codes and reset values of the sound-reactive color trigger.
// ----------------------------------------------------------------------------
package srct_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // request kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_TOGGLE = 2'd3;

  // channel that a new color leaves dark
  localparam logic [1:0] PICK_RED   = 2'd0;
  localparam logic [1:0] PICK_GREEN = 2'd1;
  localparam logic [1:0] PICK_BLUE  = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIC_BIAS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SENSITIVITY = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_STEP   = 3'd4;

  // register reset values
  localparam logic [9:0]  MIC_BIAS_RST    = 10'd287;
  localparam logic [7:0]  SENSITIVITY_RST = 8'd192;
  localparam logic [15:0] HOLDOFF_RST     = 16'd200;
  localparam logic [15:0] DECAY_RST       = 16'd300;
  localparam logic [7:0]  FADE_STEP_RST   = 8'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  sample;
    logic [31:0] now_ms;
    logic [1:0]  rand_pick;
    logic [7:0]  rand_first;
    logic [7:0]  rand_second;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  mic_bias;
    logic [7:0]  sensitivity_q8;
    logic [15:0] holdoff_ms;
    logic [15:0] decay_ms;
    logic [7:0]  fade_step;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/srct_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srct_cfg
// Configuration register file with index decode.
// ----------------------------------------------------------------------------
module srct_cfg
  import srct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_MIC_BIAS:    cfg_nxt.mic_bias       = wr_data[9:0];
        REG_SENSITIVITY: cfg_nxt.sensitivity_q8 = wr_data[7:0];
        REG_HOLDOFF:     cfg_nxt.holdoff_ms     = wr_data;
        REG_DECAY:       cfg_nxt.decay_ms       = wr_data;
        REG_FADE_STEP:   cfg_nxt.fade_step      = wr_data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mic_bias       <= MIC_BIAS_RST;
      cfg_r.sensitivity_q8 <= SENSITIVITY_RST;
      cfg_r.holdoff_ms     <= HOLDOFF_RST;
      cfg_r.decay_ms       <= DECAY_RST;
      cfg_r.fade_step      <= FADE_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hw/rtl/srct_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srct_core
// Trigger state and its single-pass update for one request.
// ----------------------------------------------------------------------------
module srct_core
  import srct_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     rgb
);

  logic        running_r, running_nxt;
  logic [9:0]  peak_r, peak_nxt;
  logic [31:0] last_change_r, last_change_nxt;
  logic [31:0] last_decay_r, last_decay_nxt;
  out_item_t   color_r, color_nxt;

  logic [9:0]  level;
  logic        raised;
  logic [9:0]  peak_up;
  logic [17:0] thresh;
  logic        trig;
  logic        hold_ok;
  logic        decay_ok;
  logic        changed;
  logic        start_en;
  logic        stop_en;
  logic        sample_en;
  out_item_t   color_pick;

  function automatic logic [7:0] fade(input logic [7:0] v, input logic [7:0] step);
    fade = (v >= step) ? (v - step) : 8'd0;
  endfunction

  always_comb begin
    level    = (item.sample >= cfg.mic_bias) ? (item.sample - cfg.mic_bias)
                                             : (cfg.mic_bias - item.sample);
    raised   = level > peak_r;
    peak_up  = raised ? level : peak_r;
    thresh   = 18'(cfg.sensitivity_q8) * 18'(peak_up);
    trig     = {level, 8'd0} >= thresh;
    hold_ok  = (item.now_ms - last_change_r) >= {16'd0, cfg.holdoff_ms};
    decay_ok = (item.now_ms - last_decay_r) >= {16'd0, cfg.decay_ms};
    changed  = hold_ok && trig;

    start_en  = !running_r && (item.kind == KIND_START || item.kind == KIND_TOGGLE);
    stop_en   = running_r && (item.kind == KIND_STOP || item.kind == KIND_TOGGLE);
    sample_en = running_r && (item.kind == KIND_SAMPLE);

    color_pick = color_r;
    if (changed) begin
      case (item.rand_pick)
        PICK_RED:   color_pick = '{8'd0, item.rand_first, item.rand_second};
        PICK_GREEN: color_pick = '{item.rand_first, 8'd0, item.rand_second};
        PICK_BLUE:  color_pick = '{item.rand_first, item.rand_second, 8'd0};
        default:    color_pick = color_r;
      endcase
    end

    running_nxt     = running_r;
    peak_nxt        = peak_r;
    last_change_nxt = last_change_r;
    last_decay_nxt  = last_decay_r;
    color_nxt       = color_r;

    if (start_en) begin
      running_nxt    = 1'b1;
      last_decay_nxt = item.now_ms;
      color_nxt      = '0;
    end else if (stop_en) begin
      running_nxt = 1'b0;
      peak_nxt    = '0;
      color_nxt   = '0;
    end else if (sample_en) begin
      peak_nxt  = peak_up;
      color_nxt = color_pick;
      if (changed) begin
        last_change_nxt = item.now_ms;
      end
      if (decay_ok) begin
        last_decay_nxt = item.now_ms;
        if (!raised && peak_r != 10'd0) begin
          peak_nxt = peak_r - 10'd1;
        end
        if (!changed) begin
          color_nxt.red   = fade(color_r.red, cfg.fade_step);
          color_nxt.green = fade(color_r.green, cfg.fade_step);
          color_nxt.blue  = fade(color_r.blue, cfg.fade_step);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r     <= 1'b0;
      peak_r        <= '0;
      last_change_r <= '0;
      last_decay_r  <= '0;
      color_r       <= '0;
    end else if (fire) begin
      running_r     <= running_nxt;
      peak_r        <= peak_nxt;
      last_change_r <= last_change_nxt;
      last_decay_r  <= last_decay_nxt;
      color_r       <= color_nxt;
    end
  end

  assign rgb = color_nxt;

endmodule
`default_nettype wire

// ===== hw/rtl/sound_reactive_color_trigger.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sound_reactive_color_trigger
// Turns microphone samples and run commands into a reactive RGB color.
// ----------------------------------------------------------------------------
// Every request (sample, start, stop or toggle) yields one RGB result. A new
// request is taken every clock cycle while in_stall is low; a request enters
// an input register, updates the trigger state in one pass and its color
// lands in the result register.
// out_stall backs up into in_stall only when both registers are full.
// Configuration writes are always ready and should be made while no request
// is in flight.
module sound_reactive_color_trigger
  import srct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic      s0_valid_r, s0_valid_nxt;
  in_item_t  s0_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      in_take;
  logic      advance;
  cfg_t      cfg;
  out_item_t rgb;

  assign cfg_ready = 1'b1;

  srct_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  srct_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (s0_item_r),
    .cfg   (cfg),
    .rgb   (rgb)
  );

  assign advance  = s0_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s0_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s0_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s0_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= rgb;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

// ===== hw/rtl/srct_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srct_checker
// Port-level checks of the color trigger, bound to the top level.
// ----------------------------------------------------------------------------
module srct_checker
  import srct_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("accepted request gave no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sound_reactive_color_trigger srct_checker u_srct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
